[src/dtpd_pkg.sv]
// Shared types and constants for the decimal token parser with value de-duplication.
// No dependencies; used by dtpd_table and decimal_token_parser_dedup.
package dtpd_pkg;

    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 10;

    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Result status codes
    localparam status_t STAT_STORED    = 3'd0;
    localparam status_t STAT_OVERFLOW  = 3'd1;
    localparam status_t STAT_DUPLICATE = 3'd2;
    localparam status_t STAT_FULL      = 3'd3;
    localparam status_t STAT_BADCHAR   = 3'd4;
    localparam status_t STAT_NOTOKEN   = 3'd5;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Largest positive magnitude; a negative token may reach one more
    localparam value_t MAG_LIMIT = 32'h7FFF_FFFF;

    // Outcome of a table scan, returned to the control logic
    typedef struct packed {
        logic done;
        logic hit;
    } scan_res_t;

endpackage

[src/decimal_token_parser_dedup.sv]
// One byte is taken per cycle while the output register is free and the byte does not end a
// token; a token end holds the input off while the table scan reads one entry per cycle.
// A result is registered the cycle after its byte, or after the scan once the output is free.
// Reset (aresetn, synchronous, active low) clears token state, error flag, stored count and
// output valid; table contents are not cleared, entries at or above the count are never read.
module decimal_token_parser_dedup #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_token_value,
    output logic [2:0]         m_status,
    output logic [9:0]         m_stored_count,
    output logic               m_end_of_text
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Control states
    localparam logic [1:0] ST_IDLE = 2'd0;  // taking bytes
    localparam logic [1:0] ST_SCAN = 2'd1;  // table scan in flight
    localparam logic [1:0] ST_FIN  = 2'd2;  // decide, write back, present result

    logic [1:0]              state_reg,  state_next;
    dtpd_pkg::value_t        acc_reg,    acc_next;     // token magnitude, at most 2^31
    logic                    neg_reg,    neg_next;
    logic                    in_tok_reg, in_tok_next;
    logic                    failed_reg, failed_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    dtpd_pkg::value_t        key_reg,    key_next;     // finished token under scan
    logic                    last_reg,   last_next;    // token came from the last byte
    logic                    hit_reg,    hit_next;

    logic                    m_valid_reg,  m_valid_next;
    dtpd_pkg::value_t        m_value_reg;
    dtpd_pkg::status_t       m_status_reg;
    logic [9:0]              m_count_reg;
    logic                    m_last_reg;

    logic                    out_free;
    logic                    s_accept;
    logic                    out_load;
    dtpd_pkg::value_t        out_value;
    dtpd_pkg::status_t       out_status;
    logic [CNT_W-1:0]        out_count;
    logic                    out_last;
    logic [CNT_W+9:0]        out_count_ext;

    logic                    scan_start;
    logic                    wr_en;
    dtpd_pkg::scan_res_t     tab_res;

    // byte decode
    logic                    is_space, is_sign, is_minus, is_digit;
    logic [7:0]              digit_diff;
    dtpd_pkg::value_t        acc_eff;
    logic                    neg_eff;
    logic [35:0]             prod;
    logic [35:0]             limit;
    logic                    ovf;
    dtpd_pkg::value_t        new_mag;
    dtpd_pkg::value_t        cur_value;
    dtpd_pkg::value_t        dig_value;

    // Output register frees up when empty or drained this cycle, so a new byte may be
    // taken while a result still waits for its transaction.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_valid && s_ready;

    assign is_space   = (s_text_byte == dtpd_pkg::CH_SPACE);
    assign is_minus   = (s_text_byte == dtpd_pkg::CH_MINUS);
    assign is_sign    = is_minus || (s_text_byte == dtpd_pkg::CH_PLUS);
    assign is_digit   = (s_text_byte >= dtpd_pkg::CH_ZERO) && (s_text_byte <= dtpd_pkg::CH_NINE);
    assign digit_diff = s_text_byte - dtpd_pkg::CH_ZERO;

    // a digit opening a token starts from a clean positive magnitude
    assign acc_eff = in_tok_reg ? acc_reg : '0;
    assign neg_eff = in_tok_reg ? neg_reg : 1'b0;

    // acc * 10 + digit as shift-add; checked against 2^31 - 1 (+1 when negative)
    assign prod  = {1'b0, acc_eff, 3'b000} + {3'b000, acc_eff, 1'b0}
                 + {32'd0, digit_diff[3:0]};
    assign limit = {4'd0, dtpd_pkg::MAG_LIMIT} + {35'd0, neg_eff};
    assign ovf   = (prod > limit);

    assign new_mag   = prod[31:0];
    assign cur_value = neg_reg ? (32'd0 - acc_reg) : acc_reg;
    assign dig_value = neg_eff ? (32'd0 - new_mag) : new_mag;

    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        in_tok_next = in_tok_reg;
        failed_next = failed_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        last_next   = last_reg;
        hit_next    = hit_reg;
        out_load    = 1'b0;
        out_value   = '0;
        out_status  = dtpd_pkg::STAT_STORED;
        out_count   = count_reg;
        out_last    = 1'b0;
        scan_start  = 1'b0;
        wr_en       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (failed_reg) begin
                        // swallow the rest of a failed text; its last byte rearms
                        if (s_last_byte) begin
                            acc_next    = '0;
                            neg_next    = 1'b0;
                            in_tok_next = 1'b0;
                            failed_next = 1'b0;
                        end
                    end else if (is_space) begin
                        if (in_tok_reg) begin
                            key_next    = cur_value;
                            last_next   = s_last_byte;
                            acc_next    = '0;
                            neg_next    = 1'b0;
                            in_tok_next = 1'b0;
                            scan_start  = 1'b1;
                            state_next  = ST_SCAN;
                        end else if (s_last_byte) begin
                            out_load   = 1'b1;
                            out_status = dtpd_pkg::STAT_NOTOKEN;
                            out_last   = 1'b1;
                        end
                    end else if (is_sign && in_tok_reg) begin
                        // sign after a digit or a second sign
                        acc_next    = '0;
                        neg_next    = 1'b0;
                        in_tok_next = 1'b0;
                        failed_next = !s_last_byte;
                        out_load    = 1'b1;
                        out_status  = dtpd_pkg::STAT_BADCHAR;
                        out_last    = s_last_byte;
                    end else if (is_sign) begin
                        in_tok_next = 1'b1;
                        neg_next    = is_minus;
                        if (s_last_byte) begin
                            // lone sign finishes as zero
                            key_next    = '0;
                            last_next   = 1'b1;
                            acc_next    = '0;
                            neg_next    = 1'b0;
                            in_tok_next = 1'b0;
                            scan_start  = 1'b1;
                            state_next  = ST_SCAN;
                        end
                    end else if (is_digit && ovf) begin
                        acc_next    = '0;
                        neg_next    = 1'b0;
                        in_tok_next = 1'b0;
                        failed_next = !s_last_byte;
                        out_load    = 1'b1;
                        out_status  = dtpd_pkg::STAT_OVERFLOW;
                        out_last    = s_last_byte;
                    end else if (is_digit) begin
                        acc_next    = new_mag;
                        neg_next    = neg_eff;
                        in_tok_next = 1'b1;
                        if (s_last_byte) begin
                            key_next    = dig_value;
                            last_next   = 1'b1;
                            acc_next    = '0;
                            neg_next    = 1'b0;
                            in_tok_next = 1'b0;
                            scan_start  = 1'b1;
                            state_next  = ST_SCAN;
                        end
                    end else begin
                        acc_next    = '0;
                        neg_next    = 1'b0;
                        in_tok_next = 1'b0;
                        failed_next = !s_last_byte;
                        out_load    = 1'b1;
                        out_status  = dtpd_pkg::STAT_BADCHAR;
                        out_last    = s_last_byte;
                    end
                end
            end
            ST_SCAN: begin
                if (tab_res.done) begin
                    hit_next   = tab_res.hit;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_value  = key_reg;
                    out_last   = last_reg;
                    state_next = ST_IDLE;
                    // duplicates take precedence over a full table
                    if (hit_reg) begin
                        out_status  = dtpd_pkg::STAT_DUPLICATE;
                        failed_next = !last_reg;
                    end else if (count_reg >= CNT_W'(TABLE_DEPTH)) begin
                        out_status  = dtpd_pkg::STAT_FULL;
                        failed_next = !last_reg;
                    end else begin
                        out_status = dtpd_pkg::STAT_STORED;
                        wr_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                        out_count  = count_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // stored count on the port is the low ten bits
    assign out_count_ext = {{dtpd_pkg::COUNT_OUT_W{1'b0}}, out_count};
    assign m_valid_next  = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            in_tok_reg  <= 1'b0;
            failed_reg  <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            in_tok_reg  <= in_tok_next;
            failed_reg  <= failed_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        last_reg <= last_next;
        hit_reg  <= hit_next;
        if (out_load) begin
            m_value_reg  <= out_value;
            m_status_reg <= out_status;
            m_count_reg  <= out_count_ext[9:0];
            m_last_reg   <= out_last;
        end
    end

    // The table is only written in ST_FIN and only scanned from ST_SCAN, so a read
    // never overlaps a write to the same entry.
    dtpd_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .key     (key_next),
        .count   (count_reg),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (key_reg),
        .res     (tab_res)
    );

    assign m_valid        = m_valid_reg;
    assign m_token_value  = $signed(m_value_reg);
    assign m_status       = m_status_reg;
    assign m_stored_count = m_count_reg;
    assign m_end_of_text  = m_last_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("stored count beyond table depth");

    a_write_bumps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("table write without count increment");

    a_failed_clears_token: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |-> !in_tok_reg)
        else $error("token still open after an error");

    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tab_res.done |-> (state_reg == ST_SCAN))
        else $error("scan completion outside scan state");

    a_no_accept_during_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_start |=> !s_ready)
        else $error("byte taken while a scan is in flight");
`endif

endmodule

[src/dtpd_table.sv]
// Value table: single-port-write, registered-read memory plus the sequential match scan.
// Depends on dtpd_pkg.
module dtpd_table #(
    parameter int DEPTH = 512,
    parameter int IDX_W = 9,
    parameter int CNT_W = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  dtpd_pkg::value_t   key,
    input  logic [CNT_W-1:0]   count,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  dtpd_pkg::value_t   wr_data,
    output dtpd_pkg::scan_res_t res
);

    dtpd_pkg::value_t mem [DEPTH];

    logic             busy_reg,    busy_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             hit_reg,     hit_next;
    logic [CNT_W-1:0] idx_reg,     idx_next;
    logic [CNT_W-1:0] lim_reg,     lim_next;
    dtpd_pkg::value_t key_reg,     key_next;
    dtpd_pkg::value_t rdata_reg;

    logic issue;
    logic done;

    assign issue = busy_reg && (idx_reg < lim_reg);
    assign done  = busy_reg && !issue && !rd_pend_reg;

    always_comb begin
        busy_next    = busy_reg;
        rd_pend_next = issue;
        hit_next     = hit_reg;
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        key_next     = key_reg;
        if (rd_pend_reg && (rdata_reg == key_reg)) begin
            hit_next = 1'b1;
        end
        if (issue) begin
            idx_next = idx_reg + 1'b1;
        end
        if (done) begin
            busy_next = 1'b0;
        end
        if (start) begin
            busy_next    = 1'b1;
            rd_pend_next = 1'b0;
            hit_next     = 1'b0;
            idx_next     = '0;
            lim_next     = count;
            key_next     = key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
            idx_reg     <= '0;
            lim_reg     <= '0;
        end else begin
            busy_reg    <= busy_next;
            rd_pend_reg <= rd_pend_next;
            hit_reg     <= hit_next;
            idx_reg     <= idx_next;
            lim_reg     <= lim_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    // memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rdata_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    assign res.done = done;
    assign res.hit  = hit_reg;

endmodule

[bench/decimal_token_parser_dedup_tb.sv]
// Self-checking bench for decimal_token_parser_dedup: byte stream in, token results out.
// Depends on dtpd_pkg for status codes and character constants; the
// scoreboard class predicts each result and checks it.
module decimal_token_parser_dedup_tb;

    localparam int TABLE_DEPTH  = 512;
    localparam int CLK_HALF     = 5;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, forces back-pressure
    localparam int RANDOM_ITEMS = 1200;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;  // worst scan plus margin

    // One expected result transaction
    typedef struct {
        dtpd_pkg::value_t  value;
        dtpd_pkg::status_t status;
        logic [9:0]        count;
        logic              eot;
    } token_result_t;

    // Predicts the parser byte by byte and holds the results still due.
    class parse_scoreboard;
        dtpd_pkg::value_t magnitude;
        bit               negative;
        bit               in_token;
        bit               failed;
        dtpd_pkg::value_t stored[TABLE_DEPTH];
        int unsigned      stored_count;
        token_result_t    results_due[$];
        int unsigned      errors;

        function new();
            magnitude    = '0;
            negative     = 1'b0;
            in_token     = 1'b0;
            failed       = 1'b0;
            stored_count = 0;
            errors       = 0;
        endfunction

        function void clear_token();
            magnitude = '0;
            negative  = 1'b0;
            in_token  = 1'b0;
        endfunction

        function bit holds(dtpd_pkg::value_t v);
            for (int unsigned k = 0; k < stored_count; k++)
                if (stored[k] == v) return 1'b1;
            return 1'b0;
        endfunction

        function void push_result(dtpd_pkg::value_t v, dtpd_pkg::status_t st, logic is_last);
            token_result_t r;
            r.value  = v;
            r.status = st;
            r.count  = stored_count[9:0];
            r.eot    = is_last;
            results_due.push_back(r);
        endfunction

        // Closes the open token: duplicate check first, then room in the table.
        function dtpd_pkg::status_t close_token(output dtpd_pkg::value_t v);
            v = negative ? (32'd0 - magnitude) : magnitude;
            clear_token();
            if (holds(v)) return dtpd_pkg::STAT_DUPLICATE;
            if (stored_count >= TABLE_DEPTH) return dtpd_pkg::STAT_FULL;
            stored[stored_count] = v;
            stored_count++;
            return dtpd_pkg::STAT_STORED;
        endfunction

        // Notes one accepted input transaction and queues the result it causes.
        function void note_byte(logic [7:0] b, logic is_last);
            dtpd_pkg::value_t  v;
            dtpd_pkg::status_t st;
            longint unsigned   n;
            longint unsigned   limit;
            if (failed) begin
                if (is_last) begin
                    clear_token();
                    failed = 1'b0;
                end
                return;
            end
            if (b == dtpd_pkg::CH_SPACE) begin
                if (in_token) begin
                    st = close_token(v);
                    if (st != dtpd_pkg::STAT_STORED) failed = !is_last;
                    push_result(v, st, is_last);
                end else if (is_last) begin
                    push_result('0, dtpd_pkg::STAT_NOTOKEN, 1'b1);
                end
                return;
            end
            if (b == dtpd_pkg::CH_MINUS || b == dtpd_pkg::CH_PLUS) begin
                if (in_token) begin
                    clear_token();
                    failed = !is_last;
                    push_result('0, dtpd_pkg::STAT_BADCHAR, is_last);
                    return;
                end
                in_token = 1'b1;
                negative = (b == dtpd_pkg::CH_MINUS);
            end else if (b >= dtpd_pkg::CH_ZERO && b <= dtpd_pkg::CH_NINE) begin
                if (!in_token) begin
                    in_token  = 1'b1;
                    negative  = 1'b0;
                    magnitude = '0;
                end
                n     = longint'(magnitude) * 10 + longint'(b - dtpd_pkg::CH_ZERO);
                limit = longint'(dtpd_pkg::MAG_LIMIT) + (negative ? 1 : 0);
                if (n > limit) begin
                    clear_token();
                    failed = !is_last;
                    push_result('0, dtpd_pkg::STAT_OVERFLOW, is_last);
                    return;
                end
                magnitude = n[31:0];
            end else begin
                clear_token();
                failed = !is_last;
                push_result('0, dtpd_pkg::STAT_BADCHAR, is_last);
                return;
            end
            if (is_last) begin
                st     = close_token(v);
                failed = 1'b0;
                push_result(v, st, 1'b1);
            end
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Checks one accepted result transaction against the oldest expectation.
        task check_result(dtpd_pkg::value_t v, dtpd_pkg::status_t st, logic [9:0] cnt,
                          logic eot);
            token_result_t e;
            if (results_due.size() == 0) begin
                report($sformatf("unexpected result value=%0d status=%0d", $signed(v), st));
                return;
            end
            e = results_due.pop_front();
            if (v !== e.value)
                report($sformatf("token_value %0d, want %0d", $signed(v), $signed(e.value)));
            if (st !== e.status)
                report($sformatf("status %0d, want %0d", st, e.status));
            if (cnt !== e.count)
                report($sformatf("stored_count %0d, want %0d", cnt, e.count));
            if (eot !== e.eot)
                report($sformatf("end_of_text %0b, want %0b", eot, e.eot));
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_text_byte;
    logic               s_last_byte;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_token_value;
    logic [2:0]         m_status;
    logic [9:0]         m_stored_count;
    logic               m_end_of_text;

    parse_scoreboard sb = new();

    // Idling controls, written by the stimulus process only
    int  src_idle   = 0;     // percent of cycles the sender holds back
    int  sink_stall = 0;     // percent of cycles the receiver stalls
    bit  want_hold  = 1'b0;  // request for the one long receiver hold-off
    int  hold_cnt   = 0;     // owned by the receiver process
    int  items_sent = 0;

    logic [7:0] text_q[$];   // bytes of the text being assembled

    decimal_token_parser_dedup #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_value (m_token_value),
        .m_status      (m_status),
        .m_stored_count(m_stored_count),
        .m_end_of_text (m_end_of_text)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off counted here so the
    // output register stays full and the parser must stall its input.
    always @(posedge aclk) begin
        if (want_hold && hold_cnt < HOLD_CYCLES) begin
            m_ready  <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    // Result monitor: values sampled at the edge are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_token_value, m_status, m_stored_count, m_end_of_text);
    end

    // One input transaction. Valid is raised once and held until accepted;
    // after acceptance it is only lowered when the sender chooses to idle.
    task send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        s_last_byte <= is_last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, is_last);
        items_sent++;
    endtask

    // Sends the assembled text, marking its final byte as the last one.
    task send_text();
        int n;
        n = text_q.size();
        for (int i = 0; i < n; i++)
            send_byte(text_q[i], i == n - 1);
        text_q.delete();
    endtask

    function void add_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function void add_sign();
        case ($urandom_range(0, 2))
            0: text_q.push_back(dtpd_pkg::CH_MINUS);
            1: text_q.push_back(dtpd_pkg::CH_PLUS);
            default: ;
        endcase
    endfunction

    // One token of random shape; mostly well formed, the rest noise.
    function void add_token();
        int    r;
        int    v;
        string edges[9];
        edges = '{"2147483647", "-2147483648", "2147483648", "-2147483649", "+0", "-0",
                  "4294967296", "99999999999", "+0000000000012"};
        r = $urandom_range(0, 99);
        if (r < 30) begin
            // small values repeat often: duplicates
            add_sign();
            add_str($sformatf("%0d", $urandom_range(0, 20)));
        end else if (r < 50) begin
            v = $urandom;
            if (v >= 0 && $urandom_range(0, 4) == 0) text_q.push_back(dtpd_pkg::CH_PLUS);
            add_str($sformatf("%0d", v));
        end else if (r < 62) begin
            add_str(edges[$urandom_range(0, 8)]);
        end else if (r < 68) begin
            text_q.push_back($urandom_range(0, 1) ? dtpd_pkg::CH_MINUS : dtpd_pkg::CH_PLUS);
        end else if (r < 74) begin
            add_sign();
            add_str($sformatf("000%0d", $urandom_range(0, 999)));
        end else if (r < 82) begin
            // long digit runs: overflow at varying positions
            add_sign();
            repeat ($urandom_range(10, 12))
                text_q.push_back(8'(dtpd_pkg::CH_ZERO + $urandom_range(0, 9)));
        end else begin
            case ($urandom_range(0, 3))
                0: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
                1: add_str($sformatf("%0d-%0d", $urandom_range(0, 99), $urandom_range(0, 9)));
                2: add_str($urandom_range(0, 1) ? "+-7" : "-+");
                default: begin
                    add_str($sformatf("%0d", $urandom_range(0, 999)));
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endfunction

    // A text of one to five tokens, with occasional leading, doubled or trailing spaces.
    task random_text();
        int ntok;
        ntok = $urandom_range(1, 5);
        if ($urandom_range(0, 9) == 0) text_q.push_back(dtpd_pkg::CH_SPACE);
        for (int i = 0; i < ntok; i++) begin
            if (i > 0) begin
                text_q.push_back(dtpd_pkg::CH_SPACE);
                if ($urandom_range(0, 7) == 0) text_q.push_back(dtpd_pkg::CH_SPACE);
            end
            add_token();
        end
        if ($urandom_range(0, 99) < 20) text_q.push_back(dtpd_pkg::CH_SPACE);
        if ($urandom_range(0, 99) < 5) text_q.push_back(dtpd_pkg::CH_SPACE);
        send_text();
    endtask

    // A value not yet held in the table, kept short to save bytes.
    function void add_fresh_value();
        int v;
        do v = int'($urandom_range(0, 199998)) - 99999;
        while (sb.holds(v));
        add_str($sformatf("%0d", v));
    endfunction

    task set_idling(input int src, input int sink);
        src_idle   <= src;
        sink_stall <= sink;
    endtask

    // Stimulus
    initial begin
        int target;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_text_byte <= '0;
        s_last_byte <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed texts
        add_str("-2147483648");                  // most negative value
        send_text();
        add_str("+");                            // lone sign gives 0
        send_text();
        add_str(" ");                            // text with no token
        send_text();
        add_str("-0 ");                          // 0 again: duplicate, then failed
        text_q.push_back(8'hFF);                 // last byte while failed: silent
        send_text();
        add_str("1-");                           // sign after a digit, on the last byte
        send_text();
        add_str("-- ");                          // second sign
        send_text();
        text_q.push_back(8'h00);                 // NUL is a bad character
        send_text();

        // Random texts over four idling phases; the first one carries the
        // long receiver hold-off while the sender keeps offering transactions.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    set_idling(0, 0);
                    want_hold <= 1'b1;
                end
                1: set_idling(45, 0);
                2: set_idling(0, 45);
                default: set_idling(29, 29);
            endcase
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target) random_text();
        end

        // Two fresh values and twelve random texts under mixed idling
        set_idling(29, 29);
        repeat (2) begin
            add_fresh_value();
            send_text();
        end
        repeat (12) random_text();

        s_valid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run (mostly table scans)
    initial begin
        #40_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
